// ----- rtl/sensor_parse_obstacle_stop_link_top_macros.svh -----
// assertion helpers used by spol_fifo.sv
`ifndef SENSOR_PARSE_OBSTACLE_STOP_LINK_TOP_MACROS_SVH
`define SENSOR_PARSE_OBSTACLE_STOP_LINK_TOP_MACROS_SVH

// same-cycle implication, off while reset is low
`define SPOL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spol: same-cycle check failed");

// next-cycle implication, off while reset is low
`define SPOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spol: next-cycle check failed");

`endif

// ----- rtl/spol_pkg.sv -----
package spol_pkg;

    // default sizing
    localparam int MAX_DIGITS_DEF = 5;
    localparam int FIFO_DEPTH_DEF = 4;

    // field widths
    localparam int THR_W   = 17;
    localparam int ID_W    = 10;
    localparam int CTR_W   = 15;
    localparam int VAL_W   = 16;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 3;
    localparam int BCD_W   = 20;
    localparam int BCD_DIG_W = 3;

    // limits
    localparam logic [THR_W-1:0] ACC_MAX = 17'd131071;
    localparam logic [ID_W-1:0]  ID_MAX  = 10'd999;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENGINE_ID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_ID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_CTR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_RNG = 3'd4;

    // register reset values
    localparam logic [THR_W-1:0] THRESHOLD_RST = 17'd20;
    localparam logic [ID_W-1:0]  ENGINE_ID_RST = 10'd1;
    localparam logic [ID_W-1:0]  SERVO_ID_RST  = 10'd2;
    localparam logic [CTR_W-1:0] SERVO_CTR_RST = 15'd90;
    localparam logic [CTR_W-1:0] SERVO_RNG_RST = 15'd60;

    // ascii codes
    localparam logic [7:0] ASCII_NUL   = 8'h00;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_9     = 8'h39;
    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_LT    = 8'h3C;
    localparam logic [7:0] ASCII_GT    = 8'h3E;

    // one packet queued for transmission
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] val;
        logic             last;
    } t_pkt;

endpackage

// ----- rtl/spol_fifo.sv -----
`include "sensor_parse_obstacle_stop_link_top_macros.svh"

module spol_fifo #(
    parameter int DEPTH = spol_pkg::FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  spol_pkg::t_pkt i_push_pkt,
    output logic          o_full,
    input  logic          i_pop,
    output spol_pkg::t_pkt o_pop_pkt,
    output logic          o_empty
);
    import spol_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pkt             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_pkt = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_pkt;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SPOL_ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full)
    `SPOL_ASSERT_IMPL(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, !o_empty)
    `SPOL_ASSERT_IMPL(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `SPOL_ASSERT_NEXT(a_count_tracks_push, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

// ----- rtl/spol_front.sv -----
module spol_front #(
    parameter int MAX_DIGITS = spol_pkg::MAX_DIGITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [spol_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [spol_pkg::CFG_W-1:0]       i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic [7:0]                       i_rx_byte,
    input  logic signed [spol_pkg::VAL_W-1:0] i_servo_value,
    input  logic signed [spol_pkg::VAL_W-1:0] i_engine_value,
    // packet queue
    output logic                             o_push,
    output spol_pkg::t_pkt                    o_push_pkt,
    input  logic                             i_full
);
    import spol_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int PROD_W = THR_W + 4;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CLASS,
        F_PUSH
    } t_fstate;

    t_fstate r_state;

    // configuration registers
    logic [THR_W-1:0] r_thr;
    logic [ID_W-1:0]  r_eng_id;
    logic [ID_W-1:0]  r_srv_id;
    logic [CTR_W-1:0] r_srv_ctr;
    logic [CTR_W-1:0] r_srv_rng;

    // captured request
    logic                    r_op;
    logic [7:0]              r_rx;
    logic signed [VAL_W-1:0] r_servo;
    logic signed [VAL_W-1:0] r_engine;

    // parser state
    logic             r_collecting;
    logic [CNT_W-1:0] r_dcnt;
    logic [THR_W-1:0] r_acc;
    logic             r_blocked;

    // pending packets
    t_pkt r_pkt_a;
    t_pkt r_pkt_b;
    logic r_two;

    logic                w_skip;
    logic                w_digit;
    logic                w_take;
    logic [PROD_W-1:0]   w_prod;
    logic [THR_W-1:0]    w_acc_next;
    logic                w_now;
    logic signed [17:0]  w_lo;
    logic signed [17:0]  w_hi;
    logic signed [17:0]  w_srv;
    logic                w_srv_ok;
    logic                w_eng_ok;
    t_pkt                w_eng_pkt;
    t_pkt                w_srv_pkt;
    t_pkt                w_stop_pkt;

    function automatic logic [ID_W-1:0] clamp_id(input logic [ID_W-1:0] id);
        return (id > ID_MAX) ? ID_MAX : id;
    endfunction

    assign o_in_ready = (r_state == F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_push_pkt = r_pkt_a;

    // byte classification and number accumulation
    always_comb begin
        w_skip     = !r_collecting && (r_rx == ASCII_NUL || r_rx == ASCII_LF);
        w_digit    = (r_rx >= ASCII_0) && (r_rx <= ASCII_9);
        w_take     = w_digit && (r_dcnt < CNT_W'(MAX_DIGITS));
        w_prod     = {4'b0, r_acc} * PROD_W'(10) + PROD_W'(r_rx - ASCII_0);
        w_acc_next = (w_prod > PROD_W'(ACC_MAX)) ? ACC_MAX : w_prod[THR_W-1:0];
        w_now      = (r_acc <= r_thr);
    end

    // steering window and command checks
    always_comb begin
        w_lo     = $signed({3'b0, r_srv_ctr}) - $signed({4'b0, r_srv_rng[CTR_W-1:1]});
        w_hi     = $signed({3'b0, r_srv_ctr}) + $signed({4'b0, r_srv_rng[CTR_W-1:1]});
        w_srv    = $signed({{2{r_servo[VAL_W-1]}}, r_servo});
        w_srv_ok = !r_servo[VAL_W-1] && (w_srv >= w_lo) && (w_srv <= w_hi);
        w_eng_ok = !r_engine[VAL_W-1];

        w_eng_pkt.id   = clamp_id(r_eng_id);
        w_eng_pkt.val  = r_engine;
        w_eng_pkt.last = !w_srv_ok;

        w_srv_pkt.id   = clamp_id(r_srv_id);
        w_srv_pkt.val  = r_servo;
        w_srv_pkt.last = 1'b1;

        w_stop_pkt.id   = clamp_id(r_eng_id);
        w_stop_pkt.val  = '0;
        w_stop_pkt.last = 1'b1;
    end

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THRESHOLD_RST;
            r_eng_id  <= ENGINE_ID_RST;
            r_srv_id  <= SERVO_ID_RST;
            r_srv_ctr <= SERVO_CTR_RST;
            r_srv_rng <= SERVO_RNG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD: r_thr     <= i_cfg_data[THR_W-1:0];
                REG_ENGINE_ID: r_eng_id  <= i_cfg_data[ID_W-1:0];
                REG_SERVO_ID:  r_srv_id  <= i_cfg_data[ID_W-1:0];
                REG_SERVO_CTR: r_srv_ctr <= i_cfg_data[CTR_W-1:0];
                REG_SERVO_RNG: r_srv_rng <= i_cfg_data[CTR_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture, classification and packet push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_collecting <= 1'b0;
            r_dcnt       <= '0;
            r_acc        <= '0;
            r_blocked    <= 1'b0;
            r_two        <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_op;
                        r_rx     <= i_rx_byte;
                        r_servo  <= i_servo_value;
                        r_engine <= i_engine_value;
                        r_state  <= F_CLASS;
                    end
                end
                F_CLASS: begin
                    // r_two is already clear here, it only rises for a two-packet command
                    if (!r_op) begin
                        if (w_skip) begin
                            r_state <= F_IDLE;
                        end else if (w_take) begin
                            r_acc        <= w_acc_next;
                            r_dcnt       <= r_dcnt + 1'b1;
                            r_collecting <= 1'b1;
                            r_state      <= F_IDLE;
                        end else begin
                            // number done: compare and flag a fresh stop
                            if (w_now && !r_blocked) begin
                                r_pkt_a <= w_stop_pkt;
                                r_state <= F_PUSH;
                            end else begin
                                r_state <= F_IDLE;
                            end
                            r_blocked    <= w_now;
                            r_collecting <= 1'b0;
                            r_dcnt       <= '0;
                            r_acc        <= '0;
                        end
                    end else if (!r_blocked) begin
                        if (w_eng_ok) begin
                            r_pkt_a <= w_eng_pkt;
                            r_pkt_b <= w_srv_pkt;
                            r_two   <= w_srv_ok;
                            r_state <= F_PUSH;
                        end else if (w_srv_ok) begin
                            r_pkt_a <= w_srv_pkt;
                            r_state <= F_PUSH;
                        end else begin
                            r_state <= F_IDLE;
                        end
                    end else begin
                        r_state <= F_IDLE;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        if (r_two) begin
                            r_pkt_a <= r_pkt_b;
                            r_two   <= 1'b0;
                        end else begin
                            r_state <= F_IDLE;
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/spol_back.sv -----
module spol_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // packet queue
    input  logic           i_empty,
    input  spol_pkg::t_pkt i_pop_pkt,
    output logic           o_pop,
    // byte channel
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_tx_byte,
    output logic           o_last
);
    import spol_pkg::*;

    localparam int ITER_W = $clog2(VAL_W);

    typedef enum logic [2:0] {
        B_IDLE,
        B_CONV,
        B_OPEN,
        B_ID,
        B_COLON,
        B_VAL,
        B_CLOSE
    } t_bstate;

    t_bstate r_state;

    t_pkt                 r_pkt;
    logic [VAL_W-1:0]     r_sh_id;
    logic [VAL_W-1:0]     r_sh_val;
    logic [BCD_W-1:0]     r_bcd_id;
    logic [BCD_W-1:0]     r_bcd_val;
    logic [ITER_W-1:0]    r_iter;
    logic [BCD_DIG_W-1:0] r_idx;
    logic                 r_out_valid;
    logic [7:0]           r_tx_byte;
    logic                 r_last;
    logic                 w_load;
    logic                 w_emit;

    // one shift-and-add-3 step of binary to bcd
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic bin_bit);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < BCD_W / 4; i++) begin
            if (adj[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bin_bit};
    endfunction

    // index of the leading nonzero digit, zero for the value zero
    function automatic logic [BCD_DIG_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
        logic [BCD_DIG_W-1:0] idx;
        idx = '0;
        for (int i = 1; i < BCD_W / 4; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                idx = BCD_DIG_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [7:0] digit_char(input logic [BCD_W-1:0] bcd,
                                              input logic [BCD_DIG_W-1:0] idx);
        logic [3:0] nib;
        nib = bcd[idx*4 +: 4];
        return ASCII_0 + {4'b0, nib};
    endfunction

    assign w_load      = !r_out_valid || i_out_ready;
    // a byte is issued in every sending state once the output slot is free
    assign w_emit      = w_load && (r_state != B_IDLE) && (r_state != B_CONV);
    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_last      = r_last;

    // packet conversion and byte sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
            r_idx       <= '0;
        end else begin
            // output slot fills on a new byte, empties when taken
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_pkt     <= i_pop_pkt;
                        r_sh_id   <= {{(VAL_W - ID_W){1'b0}}, i_pop_pkt.id};
                        r_sh_val  <= i_pop_pkt.val;
                        r_bcd_id  <= '0;
                        r_bcd_val <= '0;
                        r_iter    <= '0;
                        r_state   <= B_CONV;
                    end
                end
                B_CONV: begin
                    r_bcd_id  <= dd_step(r_bcd_id, r_sh_id[VAL_W-1]);
                    r_bcd_val <= dd_step(r_bcd_val, r_sh_val[VAL_W-1]);
                    r_sh_id   <= {r_sh_id[VAL_W-2:0], 1'b0};
                    r_sh_val  <= {r_sh_val[VAL_W-2:0], 1'b0};
                    r_iter    <= r_iter + 1'b1;
                    if (r_iter == ITER_W'(VAL_W - 1)) begin
                        r_state <= B_OPEN;
                    end
                end
                B_OPEN: begin
                    if (w_load) begin
                        r_tx_byte   <= ASCII_LT;
                        r_last      <= 1'b0;
                        r_idx       <= top_digit(r_bcd_id);
                        r_state     <= B_ID;
                    end
                end
                B_ID: begin
                    if (w_load) begin
                        r_tx_byte   <= digit_char(r_bcd_id, r_idx);
                        r_last      <= 1'b0;
                        r_idx       <= r_idx - 1'b1;
                        if (r_idx == '0) begin
                            r_state <= B_COLON;
                        end
                    end
                end
                B_COLON: begin
                    if (w_load) begin
                        r_tx_byte   <= ASCII_COLON;
                        r_last      <= 1'b0;
                        r_idx       <= top_digit(r_bcd_val);
                        r_state     <= B_VAL;
                    end
                end
                B_VAL: begin
                    if (w_load) begin
                        r_tx_byte   <= digit_char(r_bcd_val, r_idx);
                        r_last      <= 1'b0;
                        r_idx       <= r_idx - 1'b1;
                        if (r_idx == '0) begin
                            r_state <= B_CLOSE;
                        end
                    end
                end
                B_CLOSE: begin
                    if (w_load) begin
                        r_tx_byte   <= ASCII_GT;
                        r_last      <= r_pkt.last;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/sensor_parse_obstacle_stop_link_top.sv -----
// Distance link parser with obstacle stop and actuator packet writer.
// Request channel (i_in_valid / o_in_ready): i_op 0 carries one received
// sensor byte in i_rx_byte, i_op 1 carries a movement command in
// i_servo_value and i_engine_value. A finished distance at or below the
// threshold blocks motion and, on entry to the blocked state, sends
// "<motor_num:0>"; commands send "<id:value>" packets while not blocked.
// Byte channel (o_out_valid / i_out_ready): one ASCII byte per transfer,
// o_last marks the final byte caused by a request.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at once.
// Front end: a request is captured in F_IDLE, classified in F_CLASS and,
// when it queues one or two packets, pushed in F_PUSH, which waits while
// the queue is full; the next request is taken back in F_IDLE. Back end:
// each packet takes one pop, 16 steps of the binary to bcd converter and
// then one byte per cycle while the receiver is ready, 5 to 11 bytes; the
// back end emits a packet's last byte before it pops the next packet.
// Reset clears parser, blocked flag, queue and output; registers return to
// their defaults. A stalled receiver holds the current byte; the packet
// queue then fills and the request channel drops ready.
module sensor_parse_obstacle_stop_link_top #(
    parameter int MAX_DIGITS = spol_pkg::MAX_DIGITS_DEF,
    parameter int FIFO_DEPTH = spol_pkg::FIFO_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spol_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spol_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [7:0]                        i_rx_byte,
    input  logic signed [spol_pkg::VAL_W-1:0] i_servo_value,
    input  logic signed [spol_pkg::VAL_W-1:0] i_engine_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_tx_byte,
    output logic                              o_last
);
    import spol_pkg::*;

    logic w_push;
    t_pkt w_push_pkt;
    logic w_full;
    logic w_pop;
    t_pkt w_pop_pkt;
    logic w_empty;

    // parser, command check and register file
    spol_front #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_rx_byte      (i_rx_byte),
        .i_servo_value  (i_servo_value),
        .i_engine_value (i_engine_value),
        .o_push         (w_push),
        .o_push_pkt     (w_push_pkt),
        .i_full         (w_full)
    );

    // packet queue between front and back
    spol_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_pkt (w_push_pkt),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_pop_pkt  (w_pop_pkt),
        .o_empty    (w_empty)
    );

    // decimal conversion and byte output
    spol_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_pop_pkt   (w_pop_pkt),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

endmodule

// ----- tb/sensor_parse_obstacle_stop_link_top_tb.sv -----
module sensor_parse_obstacle_stop_link_top_tb;
    import spol_pkg::*;

    // request kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_WAIT  = 60;
    localparam int DRAIN_WAIT   = 100;
    localparam int STALL_LIMIT  = 3000;

    // one expected byte on the output link
    typedef struct {
        logic [7:0] tx;
        logic       fin;
    } t_out_rec;

    // tracks parser and blocked state and predicts packet bytes
    class packet_scoreboard;
        logic [THR_W-1:0] threshold;
        logic [ID_W-1:0]  eng_id;
        logic [ID_W-1:0]  srv_id;
        logic [CTR_W-1:0] srv_center;
        logic [CTR_W-1:0] srv_range;
        bit               collecting;
        int unsigned      digit_count;
        logic [THR_W-1:0] distance;
        bit               blocked;
        t_out_rec         packet_bytes[$];
        int               errors;

        function new();
            threshold   = THRESHOLD_RST;
            eng_id      = ENGINE_ID_RST;
            srv_id      = SERVO_ID_RST;
            srv_center  = SERVO_CTR_RST;
            srv_range   = SERVO_RNG_RST;
            collecting  = 0;
            digit_count = 0;
            distance    = '0;
            blocked     = 0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_THRESHOLD: threshold  = data[THR_W-1:0];
                REG_ENGINE_ID: eng_id     = data[ID_W-1:0];
                REG_SERVO_ID:  srv_id     = data[ID_W-1:0];
                REG_SERVO_CTR: srv_center = data[CTR_W-1:0];
                REG_SERVO_RNG: srv_range  = data[CTR_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_char(logic [7:0] c);
            t_out_rec rec;
            rec.tx  = c;
            rec.fin = 1'b0;
            packet_bytes.push_back(rec);
        endfunction

        // plain decimal, no leading zeros
        function void push_decimal(int unsigned v);
            logic [7:0] digs[$];
            do begin
                digs.push_front(8'(ASCII_0 + v % 10));
                v = v / 10;
            end while (v != 0);
            foreach (digs[i]) push_char(digs[i]);
        endfunction

        function void push_packet(logic [ID_W-1:0] id, int unsigned val);
            if (id > ID_MAX) id = ID_MAX;
            push_char(ASCII_LT);
            push_decimal(id);
            push_char(ASCII_COLON);
            push_decimal(val);
            push_char(ASCII_GT);
        endfunction

        function void note_request(logic op, logic [7:0] rx,
                                   logic signed [VAL_W-1:0] servo,
                                   logic signed [VAL_W-1:0] engine);
            int          first;
            int          half;
            int          lo;
            int          hi;
            int          sv;
            int          ev;
            int unsigned v;
            bit          now;
            first = packet_bytes.size();
            sv = servo;
            ev = engine;
            if (op == OP_BYTE) begin
                // skip NUL and newline before a number
                if (!collecting) begin
                    if (rx == ASCII_NUL || rx == ASCII_LF) return;
                    collecting = 1;
                end
                // gather digits up to the limit
                if (rx >= ASCII_0 && rx <= ASCII_9 && digit_count < MAX_DIGITS_DEF) begin
                    v = distance * 10 + (rx - ASCII_0);
                    distance = (v > ACC_MAX) ? ACC_MAX : v[THR_W-1:0];
                    digit_count++;
                    return;
                end
                // number done: compare with threshold
                now = (distance <= threshold);
                if (now && !blocked) push_packet(eng_id, 0);
                blocked     = now;
                collecting  = 0;
                digit_count = 0;
                distance    = '0;
            end else if (!blocked) begin
                half = int'(srv_range) / 2;
                lo   = int'(srv_center) - half;
                hi   = int'(srv_center) + half;
                if (ev >= 0) push_packet(eng_id, ev);
                if (sv >= 0 && sv >= lo && sv <= hi) push_packet(srv_id, sv);
            end
            if (packet_bytes.size() > first) packet_bytes[$].fin = 1'b1;
        endfunction

        function void check_byte(logic [7:0] tx, logic fin);
            t_out_rec exp_rec;
            if (packet_bytes.size() == 0) begin
                $error("unexpected output byte: tx_byte %h last %b", tx, fin);
                errors++;
                return;
            end
            exp_rec = packet_bytes.pop_front();
            if (tx !== exp_rec.tx) begin
                $error("tx_byte mismatch: expected %h actual %h", exp_rec.tx, tx);
                errors++;
            end
            if (fin !== exp_rec.fin) begin
                $error("last mismatch: expected %b actual %b", exp_rec.fin, fin);
                errors++;
            end
        endfunction

        function int pending();
            return packet_bytes.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_op;
    logic [7:0]              i_rx_byte;
    logic signed [VAL_W-1:0] i_servo_value;
    logic signed [VAL_W-1:0] i_engine_value;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [7:0]              o_tx_byte;
    logic                    o_last;

    packet_scoreboard sb;
    bit               idle_on;
    bit               hold_req;
    int               stall_cycles;

    sensor_parse_obstacle_stop_link_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_rx_byte      (i_rx_byte),
        .i_servo_value  (i_servo_value),
        .i_engine_value (i_engine_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_tx_byte      (o_tx_byte),
        .o_last         (o_last)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // check each output byte as it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_byte(o_tx_byte, o_last);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output side: random stalls, one long hold on demand
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    // drive one request and wait until it is taken; returns at a falling edge
    task automatic send_request(logic op, logic [7:0] rx,
                                logic signed [VAL_W-1:0] servo,
                                logic signed [VAL_W-1:0] engine);
        bit taken;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_op           = op;
        i_rx_byte      = rx;
        i_servo_value  = servo;
        i_engine_value = engine;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_in_ready;
        end
        sb.note_request(op, rx, servo, engine);
        @(negedge i_clk);
    endtask

    // sensor byte, unused fields random
    task automatic send_byte(logic [7:0] rx);
        send_request(OP_BYTE, rx, VAL_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // movement command, unused byte random
    task automatic send_move(int sv, int ev);
        send_request(OP_MOVE, 8'($urandom), VAL_W'(sv), VAL_W'(ev));
    endtask

    task automatic send_random_move();
        int lo;
        int hi;
        int sv;
        int ev;
        case ($urandom_range(0, 7))
            0: ev = -1 - int'($urandom_range(0, 32767));
            1: ev = 32767;
            2: ev = $urandom_range(0, 9);
            default: ev = $urandom_range(0, 32767);
        endcase
        // mostly near the steering window
        if ($urandom_range(0, 9) < 6) begin
            lo = int'(sb.srv_center) - int'(sb.srv_range) / 2 - 2;
            hi = int'(sb.srv_center) + int'(sb.srv_range) / 2 + 2;
            if (lo < 0) lo = 0;
            if (hi > 32767) hi = 32767;
            sv = $urandom_range(hi, lo);
        end else begin
            sv = int'($urandom_range(0, 65535)) - 32768;
        end
        send_move(sv, ev);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // stop requests and wait for every expected byte
    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // drain, then idle to let the design settle
    task automatic settle();
        wait_drain();
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    // mostly well-formed distance readings, mixed with commands and noise
    task automatic run_traffic(int n);
        int          sent;
        int          pad;
        int unsigned val;
        logic [7:0]  digs[$];
        logic [7:0]  term;
        sent = 0;
        while (sent < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    repeat ($urandom_range(0, 2)) begin
                        send_byte($urandom_range(0, 1) ? ASCII_NUL : ASCII_LF);
                        sent++;
                    end
                    case ($urandom_range(0, 4))
                        0: val = sb.threshold;
                        1: val = sb.threshold + 1;
                        2: val = $urandom_range(0, 99);
                        default: val = $urandom_range(0, 99999);
                    endcase
                    if (val > 99999) val = 99999;
                    digs.delete();
                    // an empty number now and then
                    if ($urandom_range(0, 15) != 0) begin
                        do begin
                            digs.push_front(8'(ASCII_0 + val % 10));
                            val = val / 10;
                        end while (val != 0);
                        pad = $urandom_range(0, MAX_DIGITS_DEF);
                        while (digs.size() < pad) digs.push_front(ASCII_0);
                    end
                    foreach (digs[i]) begin
                        send_byte(digs[i]);
                        sent++;
                        if ($urandom_range(0, 11) == 0) begin
                            send_random_move();
                            sent++;
                        end
                    end
                    // end of number: digit past the limit, newline or other byte
                    if (digs.size() == MAX_DIGITS_DEF && $urandom_range(0, 2) == 0) begin
                        term = 8'(ASCII_0 + $urandom_range(0, 9));
                    end else if ($urandom_range(0, 1)) begin
                        term = ASCII_LF;
                    end else begin
                        do term = 8'($urandom); while (term >= ASCII_0 && term <= ASCII_9);
                    end
                    send_byte(term);
                    sent++;
                end
                6, 7, 8: begin
                    send_random_move();
                    sent++;
                end
                default: begin
                    send_request(1'($urandom), 8'($urandom), VAL_W'($urandom),
                                 VAL_W'($urandom));
                    sent++;
                end
            endcase
        end
    endtask

    // main sequence
    initial begin
        sb             = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_op           = OP_BYTE;
        i_rx_byte      = '0;
        i_servo_value  = '0;
        i_engine_value = '0;
        idle_on        = 1;
        hold_req       = 0;
        stall_cycles   = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed checks at reset settings
        send_byte(ASCII_NUL);
        send_byte(ASCII_LF);
        send_text("15\n");
        send_move(90, 100);
        send_text("99x");
        send_move(120, 32767);
        send_move(60, -32768);
        send_move(121, 0);
        send_move(-32768, -1);
        send_text("A");
        send_text("123456");
        send_text("20\n");
        send_text("21");
        send_byte(8'hFF);
        send_byte(8'(ASCII_0 + 3));
        send_move(-5, 7);
        send_text("0\n");
        settle();

        // widest ids and window, lowest threshold, writes past the register list
        write_reg(REG_THRESHOLD, '0);
        write_reg(REG_ENGINE_ID, '1);
        write_reg(REG_SERVO_ID, CFG_W'(1000));
        write_reg(REG_SERVO_CTR, CFG_W'(32767));
        write_reg(REG_SERVO_RNG, CFG_W'(32767));
        for (int k = REG_SERVO_RNG + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), '1);
        send_text("7\n");
        send_move(32767, 32767);
        run_traffic(40);
        settle();

        // highest threshold, zero ids, single-point window
        write_reg(REG_THRESHOLD, '1);
        write_reg(REG_ENGINE_ID, '0);
        write_reg(REG_SERVO_ID, '0);
        write_reg(REG_SERVO_CTR, '0);
        write_reg(REG_SERVO_RNG, '0);
        run_traffic(15);
        settle();

        // random settings; receiver holds off while commands pile up
        write_reg(REG_THRESHOLD, CFG_W'($urandom_range(50, 5000)));
        write_reg(REG_ENGINE_ID, CFG_W'($urandom_range(0, 999)));
        write_reg(REG_SERVO_ID, CFG_W'($urandom_range(0, 999)));
        write_reg(REG_SERVO_CTR, CFG_W'($urandom_range(0, 32767)));
        write_reg(REG_SERVO_RNG, CFG_W'($urandom_range(0, 32767)));
        send_text("99999\n");
        hold_req = 1;
        repeat (12) send_move(int'(sb.srv_center), $urandom_range(0, 32767));
        run_traffic(50);
        settle();

        // wide window; sender pauses until all bytes are out
        write_reg(REG_THRESHOLD, CFG_W'(300));
        write_reg(REG_ENGINE_ID, CFG_W'(999));
        write_reg(REG_SERVO_ID, CFG_W'(999));
        write_reg(REG_SERVO_CTR, CFG_W'(16384));
        write_reg(REG_SERVO_RNG, CFG_W'(32766));
        run_traffic(30);
        wait_drain();
        run_traffic(30);
        settle();

        // final stretch without idling
        idle_on = 0;
        write_reg(REG_THRESHOLD, CFG_W'(1000));
        write_reg(REG_ENGINE_ID, CFG_W'(12));
        write_reg(REG_SERVO_ID, CFG_W'(345));
        write_reg(REG_SERVO_CTR, CFG_W'(500));
        write_reg(REG_SERVO_RNG, CFG_W'(200));
        run_traffic(60);

        wait_drain();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/spol_pkg.sv
rtl/spol_fifo.sv
rtl/spol_front.sv
rtl/spol_back.sv
rtl/sensor_parse_obstacle_stop_link_top.sv
tb/sensor_parse_obstacle_stop_link_top_tb.sv
